/* rtl/fpp_pkg.sv */
`timescale 1ns / 1ps
// Package for the fixed-point perspective projection block.
// Holds the item types, register indexes, widths, the trig table and helpers.
package fpp_pkg;

  localparam int PW   = 24;         // input coordinate width
  localparam int TW   = 12;         // trig value width, signed, range +-1024
  localparam int MW   = PW + TW;    // first rotation product width
  localparam int SW   = 39;         // product-sum width ahead of the scale-down
  localparam int RW   = 26;         // rotated coordinate width
  localparam int CDW  = 16;         // config data width
  localparam int PDW  = RW + CDW + 1; // coordinate times distance, signed
  localparam int DW   = 41;         // dividend magnitude width
  localparam int DVW  = 25;         // divisor width
  localparam int QW   = DW;         // quotient bits, one per divider stage
  localparam int OW   = QW + 2;     // width for offset and saturation
  localparam int PIPE_DEPTH = QW + 7;

  localparam int FRAC_BITS_DEF     = 8;
  localparam int SCREEN_WIDTH_DEF  = 320;
  localparam int SCREEN_HEIGHT_DEF = 240;

  localparam logic [1:0] REG_YAW   = 2'd0;
  localparam logic [1:0] REG_PITCH = 2'd1;
  localparam logic [1:0] REG_PROJ  = 2'd2;

  localparam logic [CDW-1:0] PROJ_RESET = 16'd22430;

  typedef struct packed {
    logic signed [PW-1:0] point_x;
    logic signed [PW-1:0] point_y;
    logic signed [PW-1:0] point_z;
  } point_t;

  typedef struct packed {
    logic               in_front;
    logic signed [15:0] screen_x;
    logic signed [15:0] screen_y;
  } result_t;

  typedef struct packed {
    logic [DVW-1:0] rem;
    logic [DW-1:0]  num;
  } div_lane_t;

  function automatic logic signed [TW-1:0] quarter_wave(input logic [4:0] q);
    logic signed [TW-1:0] v;
    case (q)
      5'd0:  v = 12'sd0;
      5'd1:  v = 12'sd100;
      5'd2:  v = 12'sd200;
      5'd3:  v = 12'sd297;
      5'd4:  v = 12'sd392;
      5'd5:  v = 12'sd483;
      5'd6:  v = 12'sd569;
      5'd7:  v = 12'sd650;
      5'd8:  v = 12'sd724;
      5'd9:  v = 12'sd792;
      5'd10: v = 12'sd851;
      5'd11: v = 12'sd903;
      5'd12: v = 12'sd946;
      5'd13: v = 12'sd980;
      5'd14: v = 12'sd1004;
      5'd15: v = 12'sd1019;
      5'd16: v = 12'sd1024;
      default: v = 12'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [TW-1:0] sin_of(input logic [5:0] idx);
    logic signed [TW-1:0] v;
    v = idx[4] ? quarter_wave(5'd16 - {1'b0, idx[3:0]}) : quarter_wave({1'b0, idx[3:0]});
    return idx[5] ? -v : v;
  endfunction

  function automatic logic signed [TW-1:0] cos_of(input logic [5:0] idx);
    return sin_of(idx + 6'd16);
  endfunction

  // Divide by 1024, truncating toward zero.
  function automatic logic signed [RW-1:0] scale_down(input logic signed [SW-1:0] s);
    logic signed [SW-1:0] t;
    t = s + (s[SW-1] ? SW'(1023) : SW'(0));
    t = t >>> 10;
    return t[RW-1:0];
  endfunction

  // One restoring-division step: brings in the next dividend bit.
  function automatic div_lane_t div_step(input div_lane_t l, input logic [DVW-1:0] den);
    div_lane_t  o;
    logic [DVW:0] r2;
    logic [DVW:0] diff;
    logic         qbit;
    r2   = {l.rem, l.num[DW-1]};
    diff = r2 - {1'b0, den};
    qbit = (r2 >= {1'b0, den});
    o.rem = qbit ? diff[DVW-1:0] : r2[DVW-1:0];
    o.num = {l.num[DW-2:0], qbit};
    return o;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [OW-1:0] v);
    if (v > OW'(32767)) return 16'sh7FFF;
    if (v < -OW'(32768)) return -16'sh8000;
    return v[15:0];
  endfunction

endpackage

/* rtl/fixed_point_perspective_project.sv */
`timescale 1ns / 1ps
// Accepts one item per cycle; the done strobe marks its result at the pipeline's end.
// Most of the depth is the pipelined divider, one quotient bit per stage (41 stages);
// stages 1 to 4 hold the yaw and pitch multiplies and sums, stage 5 feeds the divider.
// busy is never raised, so start may be held high every cycle.
// Synchronous active-high reset clears all valid bits and loads the config defaults.
// Depends on fpp_pkg.
module fixed_point_perspective_project import fpp_pkg::*; #(
  parameter int FRAC_BITS     = FRAC_BITS_DEF,
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  point_t         point,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [CDW-1:0] cfg_data,
  output logic           done,
  output result_t        result
);

  localparam logic signed [RW-1:0] QUARTER  = RW'((1 << FRAC_BITS) >> 2);
  localparam logic signed [OW-1:0] CENTER_X = OW'(SCREEN_WIDTH >> 1);
  localparam logic signed [OW-1:0] CENTER_Y = OW'(SCREEN_HEIGHT >> 1);

  logic [5:0]     yaw;
  logic [5:0]     pitch;
  logic [CDW-1:0] pd;

  always_ff @(posedge clk) begin
    if (rst) begin
      yaw   <= '0;
      pitch <= '0;
      pd    <= PROJ_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_YAW:   yaw   <= cfg_data[5:0];
        REG_PITCH: pitch <= cfg_data[5:0];
        REG_PROJ:  pd    <= cfg_data;
        default:   ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic signed [TW-1:0] sy, cy, sp, cp;
  logic signed [CDW:0]  pd_s;
  assign sy   = sin_of(yaw);
  assign cy   = cos_of(yaw);
  assign sp   = sin_of(pitch);
  assign cp   = cos_of(pitch);
  assign pd_s = $signed({1'b0, pd});

  // Stage 1: yaw products.
  logic                 v1;
  logic signed [MW-1:0] m_cx, m_sz, m_sx, m_cz;
  logic signed [PW-1:0] y1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= start & ~busy;
    m_cx <= cy * point.point_x;
    m_sz <= sy * point.point_z;
    m_sx <= sy * point.point_x;
    m_cz <= cy * point.point_z;
    y1   <= point.point_y;
  end

  // Stage 2: yaw sums.
  logic                 v2;
  logic signed [RW-1:0] xr2, zr2;
  logic signed [PW-1:0] y2;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else     v2 <= v1;
    xr2 <= scale_down(SW'(m_cx) - SW'(m_sz));
    zr2 <= scale_down(SW'(m_sx) + SW'(m_cz));
    y2  <= y1;
  end

  // Stage 3: pitch products and x times distance.
  logic                     v3;
  logic signed [MW-1:0]     n_cy, n_sy;
  logic signed [TW+RW-1:0]  n_sz, n_cz;
  logic signed [PDW-1:0]    px3;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else     v3 <= v2;
    n_cy <= cp * y2;
    n_sy <= sp * y2;
    n_sz <= sp * zr2;
    n_cz <= cp * zr2;
    px3  <= xr2 * pd_s;
  end

  // Stage 4: pitch sums.
  logic                  v4;
  logic signed [RW-1:0]  yr4, zp4;
  logic signed [PDW-1:0] px4;
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else     v4 <= v3;
    yr4 <= scale_down(SW'(n_cy) - SW'(n_sz));
    zp4 <= scale_down(SW'(n_sy) + SW'(n_cz));
    px4 <= px3;
  end

  // Stage 5: y times distance, magnitudes and visibility; feeds the divider.
  logic signed [PDW-1:0] py4;
  logic [PDW-1:0]        ax4, ay4;
  assign py4 = yr4 * pd_s;
  assign ax4 = px4[PDW-1] ? PDW'(-px4) : PDW'(px4);
  assign ay4 = py4[PDW-1] ? PDW'(-py4) : PDW'(py4);

  logic            dv_v   [0:QW];
  logic            dv_vis [0:QW];
  logic            dv_nx  [0:QW];
  logic            dv_ny  [0:QW];
  logic [DVW-1:0]  dv_den [0:QW];
  div_lane_t       dv_x   [0:QW];
  div_lane_t       dv_y   [0:QW];

  always_ff @(posedge clk) begin
    if (rst) dv_v[0] <= 1'b0;
    else     dv_v[0] <= v4;
    dv_vis[0] <= (zp4 > QUARTER);
    dv_nx[0]  <= px4[PDW-1];
    dv_ny[0]  <= py4[PDW-1];
    dv_den[0] <= zp4[DVW-1:0];
    dv_x[0]   <= '{rem: '0, num: ax4[DW-1:0]};
    dv_y[0]   <= '{rem: '0, num: ay4[DW-1:0]};
  end

  for (genvar g = 0; g < QW; g++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) dv_v[g+1] <= 1'b0;
      else     dv_v[g+1] <= dv_v[g];
      dv_vis[g+1] <= dv_vis[g];
      dv_nx[g+1]  <= dv_nx[g];
      dv_ny[g+1]  <= dv_ny[g];
      dv_den[g+1] <= dv_den[g];
      dv_x[g+1]   <= div_step(dv_x[g], dv_den[g]);
      dv_y[g+1]   <= div_step(dv_y[g], dv_den[g]);
    end
  end

  // Final stage A: restore sign and drop the fraction (floor).
  logic                  vf;
  logic                  visf;
  logic signed [OW-1:0]  qx, qy, shx, shy;
  assign qx = dv_nx[QW] ? -$signed(OW'(dv_x[QW].num)) : $signed(OW'(dv_x[QW].num));
  assign qy = dv_ny[QW] ? -$signed(OW'(dv_y[QW].num)) : $signed(OW'(dv_y[QW].num));
  always_ff @(posedge clk) begin
    if (rst) vf <= 1'b0;
    else     vf <= dv_v[QW];
    visf <= dv_vis[QW];
    shx  <= qx >>> FRAC_BITS;
    shy  <= qy >>> FRAC_BITS;
  end

  // Final stage B: center offset, y flip, saturation; hidden items read zero.
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= vf;
    result.in_front <= visf;
    result.screen_x <= visf ? sat16(shx + CENTER_X) : 16'sd0;
    result.screen_y <= visf ? sat16(CENTER_Y - shy) : 16'sd0;
  end

endmodule

/* rtl/fpp_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the projection block, bound to the top level.
// Depends on fpp_pkg for the item types and pipeline depth.
module fpp_checker import fpp_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    start,
  input logic    busy,
  input logic    done,
  input result_t result
);

  a_no_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  a_done_from_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, PIPE_DEPTH))
    else $error("result without an item accepted at the pipeline depth before");

  a_reset_flush: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe right after reset");

  a_hidden_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !result.in_front) |-> (result.screen_x == 16'sd0 && result.screen_y == 16'sd0))
    else $error("hidden item with nonzero screen coordinates");

endmodule

bind fixed_point_perspective_project fpp_checker u_fpp_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
